>>> design/tracking_wheel_gyro_odometry_macros.svh
// ----------------------------------------------------------------------------
// tracking wheel odometry assertion macros
// shared concurrent assertion wrappers for the rtl
// ----------------------------------------------------------------------------
`ifndef TRACKING_WHEEL_GYRO_ODOMETRY_MACROS_SVH
`define TRACKING_WHEEL_GYRO_ODOMETRY_MACROS_SVH

// implication checked on every edge outside reset
`define TWGO_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define TWGO_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> design/twgo_pkg.sv
// ----------------------------------------------------------------------------
// twgo_pkg
// types and constants for the odometry block
// ----------------------------------------------------------------------------
package twgo_pkg;

  localparam int unsigned SINE_DEPTH_DEF  = 256;
  localparam int unsigned ANGLE_BITS_DEF  = 16;
  localparam int unsigned CFG_IDX_W       = 3;

  // quarter-wave table generation constants, Q2.30
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1073741824;

  localparam logic [CFG_IDX_W-1:0] REG_DIST    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFS_X   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFS_Y   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_START_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_START_Y = 3'd5;

  localparam logic CMD_POSE = 1'b0;
  localparam logic CMD_VEL  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TRIG,
    ST_MUL,
    ST_ACC,
    ST_POS,
    ST_DONE
  } state_t;

  // serial multiply request
  typedef struct packed {
    logic              start;
    logic [63:0]       mcand;
    logic [31:0]       mplier;
  } mul_req_t;

endpackage

>>> design/twgo_if.sv
// ----------------------------------------------------------------------------
// twgo_in_if / twgo_out_if
// valid/ready channels for requests and results
// ----------------------------------------------------------------------------
interface twgo_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] x_count;
  logic [31:0] y_count;
  logic [15:0] heading;
  logic [31:0] yaw_rate;
  modport source (output valid, cmd, x_count, y_count, heading, yaw_rate, input ready);
  modport sink   (input valid, cmd, x_count, y_count, heading, yaw_rate, output ready);
endinterface

interface twgo_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] x_out;
  logic [31:0] y_out;
  logic [31:0] angle_out;
  modport source (output valid, x_out, y_out, angle_out, input ready);
  modport sink   (input valid, x_out, y_out, angle_out, output ready);
endinterface

>>> design/twgo_mul.sv
// ----------------------------------------------------------------------------
// twgo_mul
// bit-serial unsigned 64x32 multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module twgo_mul (
  input  logic                  clk,
  input  logic                  rst_n,
  input  twgo_pkg::mul_req_t    req,
  output logic                  busy,
  output logic [95:0]           prod
);

  logic [95:0] acc_r, acc_nxt;
  logic [95:0] mc_r, mc_nxt;
  logic [31:0] mp_r, mp_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;

  always_comb begin
    acc_nxt  = acc_r;
    mc_nxt   = mc_r;
    mp_nxt   = mp_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (req.start) begin
      acc_nxt  = '0;
      mc_nxt   = {32'd0, req.mcand};
      mp_nxt   = req.mplier;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (mp_r[0]) acc_nxt = acc_r + mc_r;
      mc_nxt  = mc_r << 1;
      mp_nxt  = mp_r >> 1;
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd31) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    mc_r  <= mc_nxt;
    mp_r  <= mp_nxt;
  end

  assign busy = busy_r | req.start;
  assign prod = acc_r;

endmodule

>>> design/tracking_wheel_gyro_odometry.sv
// ----------------------------------------------------------------------------
// tracking_wheel_gyro_odometry
// tracking-wheel odometry with gyro heading, bit-serial multiply datapath
// ----------------------------------------------------------------------------
// channel | dir | payload
// in_     | in  | cmd, x_count, y_count, heading, yaw_rate
// out_    | out | x_out, y_out, angle_out
// cfg_    | in  | we, idx[2:0], data[31:0]
// each request runs a sequence of serial multiplies on one shared unit, each
// a load, shift-add steps and done: velocity 2 products, pose 10 products.
// the result is valid once the last product is accumulated; the next request
// is taken only after the result has been taken with out_ready.
// one request at a time; the result register waits for out_ready while nothing
// else moves. reset clears the state machine, position state and config registers.
// ----------------------------------------------------------------------------
`include "tracking_wheel_gyro_odometry_macros.svh"

module tracking_wheel_gyro_odometry #(
  parameter int unsigned SINE_TABLE_DEPTH = twgo_pkg::SINE_DEPTH_DEF,
  parameter int unsigned ANGLE_BITS       = twgo_pkg::ANGLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  twgo_in_if.sink     in_ch,
  twgo_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [31:0] cfg_data
);

  localparam int unsigned PW = ANGLE_BITS - 2;
  localparam int unsigned IW = $clog2(SINE_TABLE_DEPTH + 1);

  // quarter-wave sine in Q2.30, polynomial evaluated at elaboration
  logic [31:0] qtab [SINE_TABLE_DEPTH+1];
  for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_tab
    localparam logic [63:0] ONE = twgo_pkg::ONE_Q30;
    localparam logic [63:0] X   = (64'(g) * twgo_pkg::HALF_PI_Q30) / 64'(SINE_TABLE_DEPTH);
    localparam logic [63:0] X2  = (X * X) >> 30;
    localparam logic [63:0] T0  = ONE - ((X2 * ONE) >> 30) / 64'd156;
    localparam logic [63:0] T1  = ONE - ((X2 * T0) >> 30) / 64'd110;
    localparam logic [63:0] T2  = ONE - ((X2 * T1) >> 30) / 64'd72;
    localparam logic [63:0] T3  = ONE - ((X2 * T2) >> 30) / 64'd42;
    localparam logic [63:0] T4  = ONE - ((X2 * T3) >> 30) / 64'd20;
    localparam logic [63:0] T5  = ONE - ((X2 * T4) >> 30) / 64'd6;
    localparam logic [63:0] S0  = (X * T5 + (ONE >> 1)) >> 30;
    localparam logic [63:0] QV  = (S0 > ONE) ? ONE : S0;
    assign qtab[g] = QV[31:0];
  end

  logic [31:0] dist_r, speed_r, ofx_r, ofy_r, stx_r, sty_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_r <= '0; speed_r <= '0; ofx_r <= '0; ofy_r <= '0; stx_r <= '0; sty_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        twgo_pkg::REG_DIST:    dist_r  <= cfg_data;
        twgo_pkg::REG_SPEED:   speed_r <= cfg_data;
        twgo_pkg::REG_OFS_X:   ofx_r   <= cfg_data;
        twgo_pkg::REG_OFS_Y:   ofy_r   <= cfg_data;
        twgo_pkg::REG_START_X: stx_r   <= cfg_data;
        twgo_pkg::REG_START_Y: sty_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // operation list: each step multiplies |a| by |b| with a sign
  // steps: 0 dx*cs 1 dy*sn 2 dy*cs 3 dx*sn 4 ox*cs 5 oy*sn 6 oy*cs 7 ox*sn
  //        8 sumx*d 9 sumy*d ; velocity uses 8,9 as dx*s, dy*s
  twgo_pkg::state_t st_r, st_nxt;
  logic [3:0]  step_r, step_nxt;
  logic        cmd_r;
  logic [31:0] xc_r, yc_r, yaw_r;
  logic [15:0] hd_r;
  logic signed [32:0] dx_r, dy_r;
  logic signed [32:0] sn_r, cs_r;
  logic [31:0] lastx_r, lasty_r;
  logic signed [47:0] sumx_r, sumy_r;
  logic signed [65:0] pa_r, pb_r;  // products for current pair
  logic signed [33:0] ro_x_r, ro_y_r;
  logic [31:0] ox_r, oy_r, ao_r;
  logic        ov_r;

  twgo_pkg::mul_req_t mreq;
  logic        mbusy, mbusy_q;
  logic [95:0] mprod;
  logic        mneg_r, mneg_nxt;

  twgo_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mreq), .busy(mbusy), .prod(mprod));

  // operand selection
  logic signed [48:0] opa;
  logic signed [32:0] opb;
  always_comb begin
    opa = '0; opb = '0;
    unique case (step_r)
      4'd0: begin opa = 49'(dx_r); opb = cs_r; end
      4'd1: begin opa = 49'(dy_r); opb = sn_r; end
      4'd2: begin opa = 49'(dy_r); opb = cs_r; end
      4'd3: begin opa = 49'(dx_r); opb = sn_r; end
      4'd4: begin opa = 49'($signed(ofx_r)); opb = cs_r; end
      4'd5: begin opa = 49'($signed(ofy_r)); opb = sn_r; end
      4'd6: begin opa = 49'($signed(ofy_r)); opb = cs_r; end
      4'd7: begin opa = 49'($signed(ofx_r)); opb = sn_r; end
      4'd8: begin
        opa = cmd_r ? 49'(dx_r) : 49'(sumx_r);
        opb = cmd_r ? $signed({1'b0, speed_r}) : $signed({1'b0, dist_r});
      end
      default: begin
        opa = cmd_r ? 49'(dy_r) : 49'(sumy_r);
        opb = cmd_r ? $signed({1'b0, speed_r}) : $signed({1'b0, dist_r});
      end
    endcase
  end

  logic [48:0] amag;
  logic [32:0] bmag;
  assign amag = opa[48] ? 49'(-opa) : 49'(opa);
  assign bmag = opb[32] ? 33'(-opb) : 33'(opb);

  // signed product result with sign restored
  logic signed [96:0] sprod;
  assign sprod = mneg_r ? -$signed({1'b0, mprod}) : $signed({1'b0, mprod});

  // trig lookup
  logic [ANGLE_BITS-1:0] ang;
  logic [1:0]  quad;
  logic [PW-1:0] ph;
  logic [IW-1:0] tix;
  logic signed [32:0] lo_v, hi_v, sn_v, cs_v;
  always_comb begin
    ang  = ANGLE_BITS'({16'd0, hd_r});
    quad = ang[ANGLE_BITS-1 -: 2];
    ph   = ang[PW-1:0];
    tix  = IW'((64'(ph) * 64'(SINE_TABLE_DEPTH)) >> PW);
    lo_v = $signed({1'b0, qtab[tix]});
    hi_v = $signed({1'b0, qtab[IW'(SINE_TABLE_DEPTH) - tix]});
    unique case (quad)
      2'd0: begin sn_v = lo_v;  cs_v = hi_v;  end
      2'd1: begin sn_v = hi_v;  cs_v = -lo_v; end
      2'd2: begin sn_v = -lo_v; cs_v = -hi_v; end
      default: begin sn_v = -hi_v; cs_v = lo_v; end
    endcase
  end

  // accumulate with round at 14 and saturate
  function automatic logic signed [47:0] sat_acc(input logic signed [47:0] s,
                                                  input logic signed [66:0] d);
    logic signed [66:0] r;
    logic signed [67:0] t;
    r = (d + 67'sd8192) >>> 14;
    t = 68'(s) + 68'(r);
    if (t > 68'sd140737488355327) return 48'sh7FFFFFFFFFFF;
    if (t < -68'sd140737488355328) return 48'sh800000000000;
    return t[47:0];
  endfunction

  function automatic logic [31:0] sat32(input logic signed [99:0] v);
    if (v > 100'sd2147483647) return 32'h7FFFFFFF;
    if (v < -100'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  // position scaling: mag*d in Q.24 rounded half away from zero
  logic [95:0] pmag;
  logic signed [99:0] pos_v;
  assign pmag  = (mprod + 96'h800000) >> 24;
  assign pos_v = mneg_r ? -$signed({4'd0, pmag}) : $signed({4'd0, pmag});
  logic [95:0] vmag;
  logic signed [99:0] vel_v;
  assign vmag  = (mprod > 96'h100000000) ? 96'h100000000 : mprod;
  assign vel_v = mneg_r ? -$signed({4'd0, vmag}) : $signed({4'd0, vmag});

  logic signed [34:0] rox_v, roy_v;
  assign rox_v = 35'((pa_r - 66'(sprod) + 66'sd536870912) >>> 30);
  assign roy_v = 35'((pa_r + 66'(sprod) + 66'sd536870912) >>> 30);

  logic accept;
  assign accept      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (st_r == twgo_pkg::ST_IDLE) && !ov_r;

  logic mdone;
  assign mdone = mbusy_q && !mbusy;

  always_comb begin
    st_nxt     = st_r;
    step_nxt   = step_r;
    mneg_nxt   = mneg_r;
    mreq.start = 1'b0;
    mreq.mcand = 64'(amag);
    mreq.mplier = bmag[31:0];
    unique case (st_r)
      twgo_pkg::ST_IDLE: if (accept) st_nxt = twgo_pkg::ST_TRIG;
      twgo_pkg::ST_TRIG: st_nxt = twgo_pkg::ST_MUL;
      twgo_pkg::ST_MUL: begin
        // cosine magnitude of one is 2^30, fits 32 bits
        mreq.start = 1'b1;
        mneg_nxt   = opa[48] ^ opb[32];
        st_nxt     = twgo_pkg::ST_ACC;
      end
      twgo_pkg::ST_ACC: if (mdone) begin
        if (step_r == 4'd9) st_nxt = twgo_pkg::ST_DONE;
        else begin
          step_nxt = step_r + 4'd1;
          st_nxt   = twgo_pkg::ST_MUL;
        end
      end
      twgo_pkg::ST_DONE: st_nxt = twgo_pkg::ST_IDLE;
      default: st_nxt = twgo_pkg::ST_IDLE;
    endcase
    if (st_r == twgo_pkg::ST_IDLE && accept) step_nxt = in_ch.cmd ? 4'd8 : 4'd0;
  end

  logic signed [32:0] dxa, dya;
  assign dxa = 33'($signed(in_ch.x_count - lastx_r));
  assign dya = 33'($signed(in_ch.y_count - lasty_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= twgo_pkg::ST_IDLE;
      step_r  <= '0;
      mbusy_q <= 1'b0;
      ov_r    <= 1'b0;
      lastx_r <= '0; lasty_r <= '0;
      sumx_r  <= '0; sumy_r  <= '0;
    end else begin
      st_r    <= st_nxt;
      step_r  <= step_nxt;
      mbusy_q <= mbusy;
      if (out_ch.valid && out_ch.ready) ov_r <= 1'b0;
      if (st_r == twgo_pkg::ST_ACC && mdone) begin
        unique case (step_r)
          4'd0, 4'd2, 4'd4, 4'd6: pa_r <= 66'(sprod);
          4'd1: sumx_r <= sat_acc(sumx_r, 67'(pa_r) - 67'(sprod));
          4'd3: sumy_r <= sat_acc(sumy_r, 67'(pa_r) + 67'(sprod));
          4'd5: ro_x_r <= 34'(rox_v);
          4'd7: ro_y_r <= 34'(roy_v);
          4'd8: pb_r <= 66'(cmd_r ? vel_v : pos_v);
          default: begin
            ov_r <= 1'b1;
            if (cmd_r) begin
              ox_r <= sat32(100'(pb_r));
              oy_r <= sat32(vel_v);
              ao_r <= yaw_r;
            end else begin
              ox_r <= sat32(100'(pb_r) + 100'(ro_x_r) - 100'($signed(ofx_r))
                            + 100'($signed(stx_r)));
              oy_r <= sat32(pos_v + 100'(ro_y_r) - 100'($signed(ofy_r))
                            + 100'($signed(sty_r)));
              ao_r <= {16'd0, hd_r};
              lastx_r <= xc_r;
              lasty_r <= yc_r;
            end
          end
        endcase
      end
    end
    if (accept) begin
      cmd_r <= in_ch.cmd;
      xc_r  <= in_ch.x_count;
      yc_r  <= in_ch.y_count;
      hd_r  <= in_ch.heading;
      yaw_r <= in_ch.yaw_rate;
      dx_r  <= dxa;
      dy_r  <= dya;
    end
    if (st_r == twgo_pkg::ST_TRIG) begin
      sn_r <= sn_v;
      cs_r <= cs_v;
    end
    mneg_r <= mneg_nxt;
  end

  assign out_ch.valid     = ov_r;
  assign out_ch.x_out     = ox_r;
  assign out_ch.y_out     = oy_r;
  assign out_ch.angle_out = ao_r;

  `TWGO_ASSERT_IMP(a_no_accept_busy, clk, rst_n, st_r != twgo_pkg::ST_IDLE, !in_ch.ready)
  `TWGO_ASSERT_NXT(a_accept_runs, clk, rst_n, accept, st_r == twgo_pkg::ST_TRIG)
  `TWGO_ASSERT_IMP(a_vel_keeps_last, clk, rst_n,
    cmd_r && st_r == twgo_pkg::ST_ACC, $stable(lastx_r))
  `TWGO_ASSERT_NXT(a_out_hold, clk, rst_n, out_ch.valid && !out_ch.ready,
    out_ch.valid && $stable(out_ch.x_out))

endmodule
